>>> src/jlp_pkg.sv
package jlp_pkg;

  // Field widths
  localparam int unsigned ChW     = 8;
  localparam int unsigned IdxW    = 8;
  localparam int unsigned CapW    = 8;
  localparam int unsigned NibW    = 4;

  // Defaults
  localparam int unsigned KeyLengthDef = 16;
  localparam logic [CapW-1:0] NameCapReset = 8'd32;

  // Fixed link head
  localparam int unsigned PfxLen = 16;
  localparam int unsigned PfxIdxW = $clog2(PfxLen);

  // Characters of interest
  localparam logic [ChW-1:0] ChNul   = 8'h00;
  localparam logic [ChW-1:0] ChSpace = 8'h20;
  localparam logic [ChW-1:0] ChDash  = 8'h2D;
  localparam logic [ChW-1:0] ChColon = 8'h3A;
  localparam logic [ChW-1:0] ChSlash = 8'h2F;
  localparam logic [ChW-1:0] ChDel   = 8'h7F;

  typedef enum logic [1:0] {
    KIND_NAME    = 2'd0,
    KIND_KEY     = 2'd1,
    KIND_VERDICT = 2'd2
  } kind_e;

  // The ok-with-key code doubles as "no error yet" in the run state
  typedef enum logic [3:0] {
    ST_OK_KEY        = 4'd0,
    ST_OK_NOKEY      = 4'd1,
    ST_BAD_PREFIX    = 4'd2,
    ST_BAD_NAME_LEN  = 4'd3,
    ST_BAD_NAME_CHAR = 4'd4,
    ST_BAD_HEX       = 4'd5,
    ST_TOO_MANY      = 4'd6,
    ST_DANGLING      = 4'd7,
    ST_SHORT_KEY     = 4'd8
  } status_e;

  typedef enum logic [2:0] {
    PH_PREFIX = 3'b001,
    PH_NAME   = 3'b010,
    PH_KEY    = 3'b100
  } phase_e;

  typedef struct packed {
    kind_e           kind;
    logic [IdxW-1:0] index;
    logic [ChW-1:0]  value;
    status_e         status;
    logic            end_res;
  } res_t;

  // Results produced by one item, in delivery order
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic [ChW-1:0] prefix_char(input logic [PfxIdxW-1:0] idx);
    logic [ChW-1:0] c;
    case (idx)
      4'd0:    c = 8'h6D; // m
      4'd1:    c = 8'h65; // e
      4'd2:    c = 8'h73; // s
      4'd3:    c = 8'h68; // h
      4'd4:    c = 8'h63; // c
      4'd5:    c = 8'h6F; // o
      4'd6:    c = 8'h72; // r
      4'd7:    c = 8'h65; // e
      4'd8:    c = 8'h3A; // :
      4'd9:    c = 8'h2F; // /
      4'd10:   c = 8'h2F; // /
      4'd11:   c = 8'h6A; // j
      4'd12:   c = 8'h6F; // o
      4'd13:   c = 8'h69; // i
      4'd14:   c = 8'h6E; // n
      default: c = 8'h2F; // /
    endcase
    return c;
  endfunction

  // Hex digit decode: bit 4 set when the character is a digit of either case
  function automatic logic [NibW:0] hex_nibble(input logic [ChW-1:0] c);
    logic [NibW:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

>>> src/jlp_core.sv
module jlp_core #(
  parameter int unsigned KEY_LENGTH = jlp_pkg::KeyLengthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [jlp_pkg::CapW-1:0]  cfg_wdata_i,
  input  logic                      step_i,
  input  logic [jlp_pkg::ChW-1:0]   ch_i,
  input  logic                      last_i,
  output jlp_pkg::push_t            push_o
);
  import jlp_pkg::*;

  localparam int unsigned KcW = $clog2(KEY_LENGTH + 1);
  localparam logic [KcW-1:0] KeyLen = KcW'(KEY_LENGTH);

  logic [CapW-1:0] cap_q;
  phase_e          phase_q, phase_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic [KcW-1:0]  kc_q, kc_d;
  logic [NibW-1:0] held_q, held_d;
  logic            pend_q, pend_d;
  status_e         err_q, err_d;
  logic            bad_q, bad_d;
  logic            ended_q, ended_d;

  logic            emit_byte;
  res_t            byte_res;
  res_t            verdict_res;
  status_e         st;
  logic [NibW:0]   hex;

  // Name capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= NameCapReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Advance the run state by one character
  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    kc_d      = kc_q;
    held_d    = held_q;
    pend_d    = pend_q;
    err_d     = err_q;
    bad_d     = bad_q;
    ended_d   = ended_q;
    emit_byte = 1'b0;
    byte_res  = '0;
    hex       = hex_nibble(ch_i);

    if (err_q == ST_OK_KEY && !ended_q) begin
      if (ch_i == ChNul) begin
        ended_d = 1'b1;
        if (phase_q == PH_PREFIX) err_d = ST_BAD_PREFIX;
      end else begin
        unique case (phase_q)
          PH_PREFIX: begin
            if (pos_q >= IdxW'(PfxLen) || ch_i != prefix_char(pos_q[PfxIdxW-1:0])) begin
              err_d = ST_BAD_PREFIX;
            end else if (pos_q == IdxW'(PfxLen - 1)) begin
              phase_d = PH_NAME;
              pos_d   = '0;
            end else begin
              pos_d = pos_q + 1'b1;
            end
          end
          PH_NAME: begin
            if (ch_i == ChSlash) begin
              if (pos_q == '0)  err_d = ST_BAD_NAME_LEN;
              else if (bad_q)   err_d = ST_BAD_NAME_CHAR;
              else              phase_d = PH_KEY;
            end else if ({1'b0, pos_q} + 9'd1 >= {1'b0, cap_q}) begin
              err_d = ST_BAD_NAME_LEN;
            end else begin
              if (ch_i < ChSpace || ch_i >= ChDel) bad_d = 1'b1;
              emit_byte      = 1'b1;
              byte_res.kind  = KIND_NAME;
              byte_res.index = pos_q;
              byte_res.value = ch_i;
              pos_d          = pos_q + 1'b1;
            end
          end
          PH_KEY: begin
            if (ch_i != ChSpace && ch_i != ChDash && ch_i != ChColon) begin
              if (!hex[NibW]) begin
                err_d = ST_BAD_HEX;
              end else if (!pend_q) begin
                held_d = hex[NibW-1:0];
                pend_d = 1'b1;
              end else if (kc_q >= KeyLen) begin
                err_d = ST_TOO_MANY;
              end else begin
                emit_byte      = 1'b1;
                byte_res.kind  = KIND_KEY;
                byte_res.index = {{(IdxW-KcW){1'b0}}, kc_q};
                byte_res.value = {held_q, hex[NibW-1:0]};
                kc_d           = kc_q + 1'b1;
                pend_d         = 1'b0;
              end
            end
          end
          default: ;
        endcase
      end
    end

    // Verdict from the state after this character
    if (err_d != ST_OK_KEY)       st = err_d;
    else if (phase_d == PH_PREFIX) st = ST_BAD_PREFIX;
    else if (phase_d == PH_NAME) begin
      if (pos_d == '0)  st = ST_BAD_NAME_LEN;
      else if (bad_d)   st = ST_BAD_NAME_CHAR;
      else              st = ST_OK_NOKEY;
    end
    else if (pend_d)          st = ST_DANGLING;
    else if (kc_d != KeyLen)  st = ST_SHORT_KEY;
    else                      st = ST_OK_KEY;

    verdict_res         = '0;
    verdict_res.kind    = KIND_VERDICT;
    verdict_res.status  = st;
    verdict_res.end_res = 1'b1;

    // Drop the run on the last character
    if (last_i) begin
      phase_d = PH_PREFIX;
      pos_d   = '0;
      kc_d    = '0;
      held_d  = '0;
      pend_d  = 1'b0;
      err_d   = ST_OK_KEY;
      bad_d   = 1'b0;
      ended_d = 1'b0;
    end
  end

  // Pack results in delivery order
  always_comb begin
    push_o = '0;
    if (step_i) begin
      push_o.n = {1'b0, emit_byte} + {1'b0, last_i};
      if (emit_byte) begin
        push_o.r0 = byte_res;
        push_o.r1 = verdict_res;
      end else begin
        push_o.r0 = verdict_res;
      end
    end
  end

  // Run state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PREFIX;
      pos_q   <= '0;
      kc_q    <= '0;
      held_q  <= '0;
      pend_q  <= 1'b0;
      err_q   <= ST_OK_KEY;
      bad_q   <= 1'b0;
      ended_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      kc_q    <= kc_d;
      held_q  <= held_d;
      pend_q  <= pend_d;
      err_q   <= err_d;
      bad_q   <= bad_d;
      ended_q <= ended_d;
    end
  end

endmodule

>>> src/jlp_out_fifo.sv
module jlp_out_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  jlp_pkg::push_t  push_i,
  output logic            room_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output jlp_pkg::res_t   out_o
);
  import jlp_pkg::*;

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  res_t            mem_q [Depth];
  logic [PtrW-1:0] rd_q, wr_q, wr_nxt;
  logic [PtrW:0]   cnt_q;
  logic            pop;

  // Accept a new item only when two slots are free
  assign room_o      = cnt_q <= (PtrW+1)'(Depth - 2);
  assign out_valid_o = cnt_q != '0;
  assign out_o       = mem_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;
  assign wr_nxt      = wr_q + 1'b1;

  // Write up to two results per cycle
  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wr_q]   <= push_i.r0;
    if (push_i.n == 2'd2) mem_q[wr_nxt] <= push_i.r1;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (pop) rd_q <= rd_q + 1'b1;
      wr_q  <= wr_q + PtrW'(push_i.n);
      cnt_q <= cnt_q + (PtrW+1)'(push_i.n) - (PtrW+1)'(pop);
    end
  end

endmodule

>>> src/join_link_parser.sv
// Channel   Direction  Handshake                   Payload
// in        input      in_valid_i / in_ready_o     ch_i, last_i
// out       output     out_valid_o / out_ready_i   kind_o, index_o, value_o, status_o, end_res_o
// cfg       input      cfg_we_i (no wait)          cfg_wdata_i (name capacity)
//
// One character is taken per cycle while the result queue has room; its results leave
// one per cycle while out_ready_i is high, from a four-entry result queue, starting the
// cycle after the character is processed. A last character with a name or key byte
// yields two results. Reset clears the run state and sets the name capacity to 32.
// Input stalls only when the result queue has fewer than two free slots.
module join_link_parser #(
  parameter int unsigned KEY_LENGTH = jlp_pkg::KeyLengthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [jlp_pkg::CapW-1:0]  cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [jlp_pkg::ChW-1:0]   ch_i,
  input  logic                      last_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                kind_o,
  output logic [jlp_pkg::IdxW-1:0]  index_o,
  output logic [jlp_pkg::ChW-1:0]   value_o,
  output logic [3:0]                status_o,
  output logic                      end_res_o
);
  import jlp_pkg::*;

  logic           in_vld_q;
  logic [ChW-1:0] ch_q;
  logic           last_q;
  logic           room;
  logic           step;
  push_t          push;
  res_t           head;

  // Process the held item when the queue has room
  assign step       = in_vld_q && room;
  assign in_ready_o = !in_vld_q || step;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ch_q   <= ch_i;
      last_q <= last_i;
    end
  end

  jlp_core #(
    .KEY_LENGTH (KEY_LENGTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .ch_i        (ch_q),
    .last_i      (last_q),
    .push_o      (push)
  );

  jlp_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (head)
  );

  assign kind_o    = head.kind;
  assign index_o   = head.index;
  assign value_o   = head.value;
  assign status_o  = head.status;
  assign end_res_o = head.end_res;

endmodule
